// ===== hw/rtl/ipfc_pkg.sv =====
// Shared types and constants for the IP packet flow classifier.
`timescale 1ns / 1ps

package ipfc_pkg;

    localparam int unsigned MAX_PACKET_BYTES = 65535;
    localparam int unsigned OFFSET_W         = $clog2(MAX_PACKET_BYTES + 1);

    localparam logic [15:0] DNS_PORT_RESET = 16'd53;
    localparam logic [3:0]  VER_IPV4       = 4'd4;
    localparam logic [3:0]  VER_IPV6       = 4'd6;
    localparam logic [5:0]  IPV4_MIN_HDR   = 6'd20;
    localparam logic [7:0]  IPV6_HDR       = 8'd40;
    localparam logic [7:0]  TCP_PROTO_NUM  = 8'd6;
    localparam logic [7:0]  UDP_PROTO_NUM  = 8'd17;
    localparam logic [3:0]  NIBBLE_MASK    = 4'hF;

    // Byte positions inside the IPv4 header
    localparam logic [OFFSET_W-1:0] POS_PROTOCOL = OFFSET_W'(9);
    localparam logic [OFFSET_W-1:0] POS_DST_LO   = OFFSET_W'(16);
    localparam logic [OFFSET_W-1:0] POS_DST_HI   = OFFSET_W'(19);

    typedef enum logic [1:0] {
        CLASS_MALFORMED = 2'd0,
        CLASS_DNS       = 2'd1,
        CLASS_PASS      = 2'd2
    } t_verdict;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        t_verdict    verdict;
        logic [31:0] dest_ip;
    } t_out_item;

endpackage

// ===== hw/rtl/ipfc_parser.sv =====
// Per-packet field capture and verdict logic of the IP packet flow classifier.
`timescale 1ns / 1ps

module ipfc_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  ipfc_pkg::t_in_item  i_item,
    input  logic [15:0]         i_dns_port,
    output ipfc_pkg::t_out_item o_result
);

    logic [ipfc_pkg::OFFSET_W-1:0] r_byte_offset, n_byte_offset;
    logic [3:0]  r_ip_version, n_ip_version;
    logic [5:0]  r_header_bytes, n_header_bytes;
    logic [7:0]  r_protocol, n_protocol;
    logic [31:0] r_dest_addr, n_dest_addr;
    logic [15:0] r_dest_port, n_dest_port;

    logic [ipfc_pkg::OFFSET_W-1:0] w_pos;
    logic [ipfc_pkg::OFFSET_W-1:0] w_port_hi_pos;
    logic [ipfc_pkg::OFFSET_W-1:0] w_port_lo_pos;
    logic [ipfc_pkg::OFFSET_W:0]   w_len_x;
    logic [ipfc_pkg::OFFSET_W:0]   w_hdr_x;
    logic        w_v4_ok;
    logic        w_has_ports;

    assign w_pos         = r_byte_offset;
    assign w_port_hi_pos = ipfc_pkg::OFFSET_W'(r_header_bytes) + ipfc_pkg::OFFSET_W'(2);
    assign w_port_lo_pos = ipfc_pkg::OFFSET_W'(r_header_bytes) + ipfc_pkg::OFFSET_W'(3);

    // Capture fields of the current byte
    always_comb begin
        n_byte_offset  = r_byte_offset;
        n_ip_version   = r_ip_version;
        n_header_bytes = r_header_bytes;
        n_protocol     = r_protocol;
        n_dest_addr    = r_dest_addr;
        n_dest_port    = r_dest_port;
        if (r_byte_offset != ipfc_pkg::OFFSET_W'(ipfc_pkg::MAX_PACKET_BYTES)) begin
            n_byte_offset = r_byte_offset + ipfc_pkg::OFFSET_W'(1);
            if (w_pos == '0) begin
                n_ip_version   = i_item.packet_byte[7:4];
                n_header_bytes = {i_item.packet_byte[3:0] & ipfc_pkg::NIBBLE_MASK, 2'b00};
            end else begin
                if (w_pos == ipfc_pkg::POS_PROTOCOL) begin
                    n_protocol = i_item.packet_byte;
                end
                if (w_pos >= ipfc_pkg::POS_DST_LO && w_pos <= ipfc_pkg::POS_DST_HI) begin
                    n_dest_addr = {r_dest_addr[23:0], i_item.packet_byte};
                end
                if (w_pos == w_port_hi_pos) begin
                    n_dest_port = {i_item.packet_byte, r_dest_port[7:0]};
                end
                if (w_pos == w_port_lo_pos) begin
                    n_dest_port = {r_dest_port[15:8], i_item.packet_byte};
                end
            end
        end
    end

    // Judge the packet on the state that includes this byte
    assign w_len_x     = {1'b0, n_byte_offset};
    assign w_hdr_x     = (ipfc_pkg::OFFSET_W + 1)'(n_header_bytes);
    assign w_has_ports = (n_protocol == ipfc_pkg::TCP_PROTO_NUM)
                      || (n_protocol == ipfc_pkg::UDP_PROTO_NUM);
    assign w_v4_ok     = (w_len_x >= (ipfc_pkg::OFFSET_W + 1)'(ipfc_pkg::IPV4_MIN_HDR))
                      && (n_header_bytes >= ipfc_pkg::IPV4_MIN_HDR)
                      && (w_hdr_x <= w_len_x)
                      && !(w_has_ports
                           && (w_len_x < w_hdr_x + (ipfc_pkg::OFFSET_W + 1)'(4)));

    always_comb begin
        o_result.verdict = ipfc_pkg::CLASS_MALFORMED;
        o_result.dest_ip = '0;
        if (n_ip_version == ipfc_pkg::VER_IPV6) begin
            if (w_len_x >= (ipfc_pkg::OFFSET_W + 1)'(ipfc_pkg::IPV6_HDR)) begin
                o_result.verdict = ipfc_pkg::CLASS_PASS;
            end
        end else if (n_ip_version == ipfc_pkg::VER_IPV4 && w_v4_ok) begin
            o_result.dest_ip = n_dest_addr;
            if (n_protocol == ipfc_pkg::UDP_PROTO_NUM && n_dest_port == i_dns_port) begin
                o_result.verdict = ipfc_pkg::CLASS_DNS;
            end else begin
                o_result.verdict = ipfc_pkg::CLASS_PASS;
            end
        end
    end

    // Advance on each byte, drop all packet state after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.last_byte)) begin
            r_byte_offset  <= '0;
            r_ip_version   <= '0;
            r_header_bytes <= '0;
            r_protocol     <= '0;
            r_dest_addr    <= '0;
            r_dest_port    <= '0;
        end else if (i_step) begin
            r_byte_offset  <= n_byte_offset;
            r_ip_version   <= n_ip_version;
            r_header_bytes <= n_header_bytes;
            r_protocol     <= n_protocol;
            r_dest_addr    <= n_dest_addr;
            r_dest_port    <= n_dest_port;
        end
    end

endmodule

// ===== hw/rtl/ip_packet_flow_classifier.sv =====
// Top level of the IP packet flow classifier: input register, parser, result register.
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+------------------------------
//  in       | input     | i_in_valid / o_in_ready  | i_in  : one packet byte + last
//  out      | output    | o_out_valid / i_out_ready| o_out : verdict + dest address
//  cfg      | input     | i_cfg_valid / o_cfg_ready| i_cfg_data : DNS port
//
// One byte per cycle unless a last byte waits on a stalled result; the verdict of a
// last byte is written to the result register as that byte leaves the input register.
// The per-byte step is a compare and capture against the parser state, one pass per cycle.
// Reset is synchronous, active low; it clears packet state and sets the DNS port to 53.
// A stalled result stops only a last byte, which then holds the input; others keep flowing.
`timescale 1ns / 1ps

module ip_packet_flow_classifier (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ipfc_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ipfc_pkg::t_out_item o_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [15:0]         i_cfg_data
);

    logic                r_in_valid;
    ipfc_pkg::t_in_item  r_in;
    logic                r_out_valid;
    ipfc_pkg::t_out_item r_out;
    logic [15:0]         r_dns_port;

    logic                w_proc;
    ipfc_pkg::t_out_item w_result;

    // A byte that is not last needs no result slot
    assign w_proc = r_in_valid && (!r_in.last_byte || !r_out_valid || i_out_ready);

    assign o_in_ready  = !r_in_valid || w_proc;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    ipfc_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_proc),
        .i_item     (r_in),
        .i_dns_port (r_dns_port),
        .o_result   (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc && r_in.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && r_in.last_byte) begin
            r_out <= w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dns_port <= ipfc_pkg::DNS_PORT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_dns_port <= i_cfg_data;
        end
    end

`ifndef SYNTHESIS
    a_last_makes_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc && r_in.last_byte |=> r_out_valid)
        else $error("last byte processed without a result");

    a_malformed_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.verdict == ipfc_pkg::CLASS_MALFORMED
            |-> r_out.dest_ip == '0)
        else $error("malformed verdict with nonzero address");

    a_stall_holds_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_valid && r_in.last_byte && r_out_valid && !i_out_ready)
        else $error("input stalled without a blocked result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid)
        else $error("pending result lost");
`endif

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the IP packet flow classifier.
`timescale 1ns / 1ps

module tb_top;

    localparam int LONG_HOLD     = 80;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_BYTES   = 80;
    localparam int PHASE_PKTS    = 3;
    localparam logic [7:0] PROTO_ICMP = 8'd1;

    // Tracks the parser state per packet and queues the verdict due on each last byte
    class flow_verdict_board;
        logic [15:0]         dns_port;
        logic [15:0]         byte_count;
        logic [3:0]          version;
        logic [5:0]          hdr_len;
        logic [7:0]          proto;
        logic [31:0]         dst_addr;
        logic [15:0]         dst_port;
        ipfc_pkg::t_out_item verdicts_due[$];
        int                  errors;

        function new();
            dns_port = ipfc_pkg::DNS_PORT_RESET;
            errors   = 0;
            clear_packet();
        endfunction

        function void clear_packet();
            byte_count = '0;
            version    = '0;
            hdr_len    = '0;
            proto      = '0;
            dst_addr   = '0;
            dst_port   = '0;
        endfunction

        function void grab_field(int unsigned pos, logic [7:0] b);
            if (pos == 0) begin
                version = b[7:4];
                hdr_len = {b[3:0] & ipfc_pkg::NIBBLE_MASK, 2'b00};
                return;
            end
            if (pos == 9)
                proto = b;
            if (pos >= 16 && pos <= 19)
                dst_addr = {dst_addr[23:0], b};
            if (pos == int'(hdr_len) + 2)
                dst_port[15:8] = b;
            if (pos == int'(hdr_len) + 3)
                dst_port[7:0] = b;
        endfunction

        function void take_byte(ipfc_pkg::t_in_item it);
            int unsigned         len;
            logic                ok;
            logic                has_ports;
            ipfc_pkg::t_out_item want;
            // bytes past the saturation point are ignored
            if (byte_count < ipfc_pkg::MAX_PACKET_BYTES) begin
                grab_field(byte_count, it.packet_byte);
                byte_count++;
            end
            if (!it.last_byte)
                return;
            len = byte_count;
            want.verdict = ipfc_pkg::CLASS_MALFORMED;
            want.dest_ip = '0;
            if (version == ipfc_pkg::VER_IPV6) begin
                if (len >= ipfc_pkg::IPV6_HDR)
                    want.verdict = ipfc_pkg::CLASS_PASS;
            end else if (version == ipfc_pkg::VER_IPV4) begin
                ok = len >= ipfc_pkg::IPV4_MIN_HDR && hdr_len >= ipfc_pkg::IPV4_MIN_HDR
                     && hdr_len <= len;
                has_ports = proto == ipfc_pkg::TCP_PROTO_NUM
                         || proto == ipfc_pkg::UDP_PROTO_NUM;
                if (ok && has_ports && len < int'(hdr_len) + 4)
                    ok = 1'b0;
                if (ok) begin
                    want.dest_ip = dst_addr;
                    if (proto == ipfc_pkg::UDP_PROTO_NUM && dst_port == dns_port)
                        want.verdict = ipfc_pkg::CLASS_DNS;
                    else
                        want.verdict = ipfc_pkg::CLASS_PASS;
                end
            end
            verdicts_due.push_back(want);
            clear_packet();
        endfunction

        function void check_verdict(ipfc_pkg::t_out_item got);
            ipfc_pkg::t_out_item want;
            if (verdicts_due.size() == 0) begin
                $error("unexpected result: verdict %0d address %08h",
                       got.verdict, got.dest_ip);
                errors++;
                return;
            end
            want = verdicts_due.pop_front();
            if (got.verdict !== want.verdict) begin
                $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
                errors++;
            end
            if (got.dest_ip !== want.dest_ip) begin
                $error("dest_ip: expected %08h, got %08h", want.dest_ip, got.dest_ip);
                errors++;
            end
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    ipfc_pkg::t_in_item  i_in = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    ipfc_pkg::t_out_item o_out;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [15:0]         i_cfg_data = '0;

    flow_verdict_board book;
    logic [7:0] frame[$];
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_req = 0;
    int hold_taken = 0;
    int hold_left = 0;

    ip_packet_flow_classifier dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_req != hold_taken) begin
            hold_taken  <= hold_req;
            hold_left   <= LONG_HOLD;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= $urandom_range(99) >= rx_stall_pct;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            book.check_verdict(o_out);
    end

    task automatic send_item(logic [7:0] b, logic last);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= '{packet_byte: b, last_byte: last};
        do @(posedge i_clk); while (!o_in_ready);
        book.take_byte('{packet_byte: b, last_byte: last});
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame.size(); i++)
            send_item(frame[i], i == frame.size() - 1);
    endtask

    // Drop valid, wait for every verdict, then let the pipeline settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_dns_port(logic [15:0] port);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= port;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        book.dns_port = port;
    endtask

    function automatic void fill_random(int total);
        frame.delete();
        for (int i = 0; i < total; i++)
            frame.push_back(8'($urandom));
    endfunction

    function automatic void build_ipv4(int ihl, logic [7:0] proto, logic [15:0] dport,
                                       logic [31:0] dst, int total);
        int hp;
        hp = ihl * 4;
        fill_random(total);
        frame[0] = {ipfc_pkg::VER_IPV4, 4'(ihl)};
        if (total > 9)
            frame[9] = proto;
        for (int i = 0; i < 4; i++)
            if (total > 16 + i)
                frame[16 + i] = dst[31 - 8*i -: 8];
        if (total > hp + 2)
            frame[hp + 2] = dport[15:8];
        if (total > hp + 3)
            frame[hp + 3] = dport[7:0];
    endfunction

    function automatic void build_ipv6(int total);
        fill_random(total);
        frame[0][7:4] = ipfc_pkg::VER_IPV6;
    endfunction

    function automatic void build_random_frame();
        int          pick;
        int          ihl;
        int          hp;
        logic [7:0]  proto;
        logic [15:0] dport;
        pick = $urandom_range(99);
        ihl  = $urandom_range(1) ? 5 : $urandom_range(5, 15);
        hp   = ihl * 4;
        case ($urandom_range(3))
            0, 1:    proto = ipfc_pkg::UDP_PROTO_NUM;
            2:       proto = ipfc_pkg::TCP_PROTO_NUM;
            default: proto = 8'($urandom);
        endcase
        dport = $urandom_range(1) ? book.dns_port : 16'($urandom);
        if (pick < 70)
            build_ipv4(ihl, proto, dport, $urandom, hp + 4 + $urandom_range(0, 8));
        else if (pick < 78)
            build_ipv4(ihl, proto, dport, $urandom, $urandom_range(1, hp + 3));
        else if (pick < 84)
            build_ipv4($urandom_range(0, 4), proto, dport, $urandom, $urandom_range(1, 40));
        else if (pick < 92)
            build_ipv6($urandom_range(30, 56));
        else
            fill_random($urandom_range(1, 40));
    endfunction

    task automatic run_random(int n_bytes);
        int sent;
        int pkts;
        sent = 0;
        pkts = 0;
        while (sent < n_bytes || pkts < PHASE_PKTS) begin
            build_random_frame();
            send_frame();
            sent += frame.size();
            pkts++;
        end
    endtask

    initial begin
        #4_000_000;
        $display("[ip_packet_flow_classifier] ERROR");
        $finish;
    end

    initial begin
        book = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-byte packets
        fill_random(1); frame[0] = 8'h45; send_frame();
        fill_random(1); frame[0] = 8'h00; send_frame();
        fill_random(1); frame[0] = 8'hFF; send_frame();
        // minimal headers, DNS and near misses
        build_ipv4(5, PROTO_ICMP, 16'd53, 32'hFFFF_FFFF, 20); send_frame();
        build_ipv4(5, ipfc_pkg::UDP_PROTO_NUM, 16'd53, 32'h0000_0000, 28); send_frame();
        build_ipv4(5, ipfc_pkg::UDP_PROTO_NUM, 16'd54, 32'hC0A8_0001, 28); send_frame();
        build_ipv4(5, ipfc_pkg::TCP_PROTO_NUM, 16'd53, 32'h0A00_0001, 40); send_frame();
        build_ipv4(5, ipfc_pkg::UDP_PROTO_NUM, 16'd53, 32'h0808_0808, 23); send_frame();
        build_ipv4(5, ipfc_pkg::UDP_PROTO_NUM, 16'd53, 32'h0808_0404, 24); send_frame();
        build_ipv4(5, PROTO_ICMP, 16'd0, 32'h1234_5678, 19); send_frame();
        // header length below minimum and beyond the packet
        build_ipv4(4, ipfc_pkg::UDP_PROTO_NUM, 16'd53, 32'hFFFF_FFFF, 40); send_frame();
        build_ipv4(0, PROTO_ICMP, 16'd53, 32'h7F00_0001, 24); send_frame();
        build_ipv4(15, PROTO_ICMP, 16'd0, 32'hAABB_CCDD, 59); send_frame();
        build_ipv4(15, PROTO_ICMP, 16'd0, 32'hAABB_CCDD, 60); send_frame();
        build_ipv4(15, ipfc_pkg::UDP_PROTO_NUM, 16'd53, 32'hFFFF_FFFF, 64); send_frame();
        // IPv6 around the fixed header size
        build_ipv6(39); send_frame();
        build_ipv6(40); send_frame();
        // unknown versions
        fill_random(30); frame[0] = 8'h05; send_frame();
        fill_random(30); frame[0] = 8'hF5; send_frame();
        fill_random(30); frame[0] = 8'h55; send_frame();

        write_dns_port(16'h0000);
        tx_idle_pct = 0; rx_stall_pct = 0;
        run_random(PHASE_BYTES);

        write_dns_port(16'hFFFF);
        tx_idle_pct = 71; rx_stall_pct = 0;
        run_random(PHASE_BYTES);

        write_dns_port(16'($urandom));
        tx_idle_pct = 0; rx_stall_pct = 71;
        run_random(PHASE_BYTES);

        write_dns_port(ipfc_pkg::DNS_PORT_RESET);
        tx_idle_pct = 37; rx_stall_pct = 37;
        run_random(PHASE_BYTES);

        // hold the receiver off while short packets keep coming, so the input backs up
        drain();
        tx_idle_pct = 0; rx_stall_pct = 0;
        hold_req++;
        for (int k = 0; k < 30; k++) begin
            if (k % 3 == 0)
                build_ipv4(5, ipfc_pkg::UDP_PROTO_NUM, book.dns_port, $urandom, 28);
            else
                fill_random(1);
            send_frame();
        end

        drain();
        if (book.pending() != 0)
            $error("%0d verdicts never arrived", book.pending());
        if (book.errors == 0 && book.pending() == 0) begin
            $display("[ip_packet_flow_classifier] OK");
        end else begin
            $display("[ip_packet_flow_classifier] ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/ipfc_pkg.sv
hw/rtl/ipfc_parser.sv
hw/rtl/ip_packet_flow_classifier.sv
sim/tb_top.sv
